@@ src/sacl_pkg.sv @@
// Shared types and fixed field widths of the set-associative cache lookup.
package sacl_pkg;

    localparam int ADDR_W    = 32;
    localparam int WAY_OUT_W = 2;
    localparam int CNT_W     = 32;

    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [WAY_OUT_W-1:0] t_way_out;
    typedef logic [CNT_W-1:0]     t_count;

    typedef struct packed {
        logic hit;
        logic evicted;
    } t_lookup_flags;

endpackage

@@ src/sacl_req_if.sv @@
// Access request channel: valid/ready with one byte address.
interface sacl_req_if import sacl_pkg::*; ();
    logic  valid;
    logic  ready;
    t_addr access_address;

    modport source (output valid, output access_address, input ready);
    modport sink   (input valid, input access_address, output ready);
endinterface

@@ src/sacl_rsp_if.sv @@
// Lookup result channel: valid/ready with hit, way and running totals.
interface sacl_rsp_if import sacl_pkg::*; ();
    logic     valid;
    logic     ready;
    logic     hit;
    t_way_out way_used;
    logic     evicted;
    t_count   hit_total;
    t_count   miss_total;

    modport source (output valid, output hit, output way_used, output evicted,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input hit, input way_used, input evicted,
                    input hit_total, input miss_total, output ready);
endinterface

@@ src/sacl_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sacl_index.sv @@
// Address split stage: line number, tag by reciprocal multiply, set index remainder.
module sacl_index import sacl_pkg::*; #(
    parameter int SETS       = 64,
    parameter int LINE_BYTES = 32,
    parameter int ADDRESS_BITS = 32,
    localparam int ADDR_EFF = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W,
    localparam int OFF_W    = $clog2(LINE_BYTES + 1) - 1,
    localparam int LINE_W   = ADDR_EFF - OFF_W,
    localparam int SET_FL   = $clog2(SETS + 1) - 1,
    localparam int TAG_W    = LINE_W - SET_FL,
    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  t_addr            i_addr,
    output logic [SET_W-1:0] o_set,
    output logic [TAG_W-1:0] o_tag
);

    // floor(line / SETS) == (line * RECIP) >> SHIFT for every line below 2^LINE_W
    localparam int RL     = $clog2(SETS);
    localparam int SHIFT  = LINE_W + RL;
    localparam int MUL_W  = LINE_W + 1;
    localparam int PROD_W = LINE_W + MUL_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS);
    localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_FULL);

    logic [LINE_W-1:0] line;
    logic [PROD_W-1:0] prod;
    logic [LINE_W-1:0] r_line;
    logic [TAG_W-1:0]  r_q;
    logic [LINE_W-1:0] q_ext;
    logic [LINE_W-1:0] rem;

    assign line = i_addr[ADDR_EFF-1:OFF_W];
    assign prod = PROD_W'(line) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_line <= line;
            r_q    <= prod[SHIFT +: TAG_W];
        end
    end

    assign q_ext = LINE_W'(r_q);
    assign rem   = r_line - q_ext * LINE_W'(SETS);
    assign o_set = rem[SET_W-1:0];
    assign o_tag = r_q;

endmodule

@@ src/sacl_way_sel.sv @@
// Tag compare, fill/victim choice and LRU rank update for one set.
module sacl_way_sel import sacl_pkg::*; #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 21,
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int AGE_W = WAY_W
) (
    input  logic [WAYS-1:0]             i_valid,
    input  logic [WAYS-1:0][AGE_W-1:0]  i_age,
    input  logic [WAYS-1:0][TAG_W-1:0]  i_tag_row,
    input  logic [TAG_W-1:0]            i_tag,
    output t_lookup_flags               o_flags,
    output logic [WAY_W-1:0]            o_way,
    output logic [WAYS-1:0]             o_valid_next,
    output logic [WAYS-1:0][AGE_W-1:0]  o_age_next
);

    localparam int OLD_W = AGE_W + 1;

    logic             hit;
    logic             has_free;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] victim_way;
    logic [WAY_W-1:0] way;
    logic [OLD_W-1:0] old_rank;

    // lowest way wins on every search
    always_comb begin
        hit        = 1'b0;
        has_free   = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        victim_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_valid[w] && (i_tag_row[w] == i_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!i_valid[w]) begin
                has_free = 1'b1;
                free_way = WAY_W'(w);
            end
            // a full set holds ranks 0..WAYS-1, so the oldest is the top rank
            if (i_age[w] == AGE_W'(WAYS - 1)) begin
                victim_way = WAY_W'(w);
            end
        end
    end

    assign way = hit ? hit_way : (has_free ? free_way : victim_way);
    assign old_rank = i_valid[way] ? {1'b0, i_age[way]} : OLD_W'(WAYS);

    always_comb begin
        o_valid_next = i_valid;
        o_valid_next[way] = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == way) begin
                o_age_next[w] = '0;
            end else if (i_valid[w] && ({1'b0, i_age[w]} < old_rank)) begin
                o_age_next[w] = i_age[w] + AGE_W'(1);
            end else begin
                o_age_next[w] = i_age[w];
            end
        end
    end

    assign o_way           = way;
    assign o_flags.hit     = hit;
    assign o_flags.evicted = !hit && !has_free;

endmodule

@@ src/set_assoc_cache_lru_lookup_unit.sv @@
// Set-associative cache lookup with LRU replacement: top level.
//
// i_req carries one byte address per transfer; o_rsp returns one result per
// address: hit, way used, eviction flag and running hit/miss totals (wrap at
// 2^32). Three registered stages: address split (tag by reciprocal multiply,
// set by remainder), set row read from the tag and state RAMs, and tag compare
// plus LRU update into the output register. One request is taken every cycle
// while o_rsp does not stall, limited by the single write and read port of
// each RAM (same-set back-to-back accesses are forwarded). Tags and per-set
// valid/rank rows are one RAM row per set. After reset a clearing pass
// writes every state row with i_req.ready low. When o_rsp stalls the output
// register holds its result and the stages behind it keep filling;
// i_req.ready drops once all three hold an item.
module set_assoc_cache_lru_lookup_unit import sacl_pkg::*; #(
    parameter int WAYS         = 4,
    parameter int SETS         = 64,
    parameter int LINE_BYTES   = 32,
    parameter int ADDRESS_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sacl_req_if.sink   i_req,
    sacl_rsp_if.source o_rsp
);

    localparam int ADDR_EFF = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam int OFF_W    = $clog2(LINE_BYTES + 1) - 1;
    localparam int LINE_W   = ADDR_EFF - OFF_W;
    localparam int SET_FL   = $clog2(SETS + 1) - 1;
    localparam int TAG_W    = LINE_W - SET_FL;
    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int ST_W     = WAYS * (1 + AGE_W);
    localparam int TR_W     = WAYS * TAG_W;

    // handshake and stage control
    logic clearing;
    logic out_free;
    logic b_adv;
    logic b_free;
    logic a_adv;
    logic a_free;
    logic a_accept;

    logic             r_a_valid;
    logic             r_b_valid;
    logic             r_out_valid;
    logic             r_clr_done;
    logic [SET_W-1:0] r_clr_cnt;
    t_count           r_hit_cnt;
    t_count           r_miss_cnt;

    logic [SET_W-1:0] a_set;
    logic [TAG_W-1:0] a_tag;
    logic [SET_W-1:0] r_b_set;
    logic [TAG_W-1:0] r_b_tag;

    logic             r_fwd;
    logic [ST_W-1:0]  r_fwd_state;
    logic [TR_W-1:0]  r_fwd_tags;

    logic [ST_W-1:0]  st_rdata;
    logic [TR_W-1:0]  tag_rdata;
    logic [ST_W-1:0]  b_state;
    logic [TR_W-1:0]  b_tags_flat;

    logic [WAYS-1:0]             b_valid;
    logic [WAYS-1:0][AGE_W-1:0]  b_age;
    logic [WAYS-1:0][TAG_W-1:0]  b_tags;
    t_lookup_flags               b_flags;
    logic [WAY_W-1:0]            b_way;
    logic [WAYS-1:0]             valid_next;
    logic [WAYS-1:0][AGE_W-1:0]  age_next;
    logic [WAYS-1:0][TAG_W-1:0]  tags_next;
    logic [ST_W-1:0]             state_new;
    logic [TR_W-1:0]             tags_new;

    logic             st_we;
    logic [SET_W-1:0] st_waddr;
    logic [ST_W-1:0]  st_wdata;

    t_count            n_hit_cnt;
    t_count            n_miss_cnt;
    logic [WAY_W+1:0]  way_ext;

    logic              r_out_hit;
    logic              r_out_evicted;
    t_way_out          r_out_way;
    t_count            r_out_hit_total;
    t_count            r_out_miss_total;

    assign clearing = !r_clr_done;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign b_adv    = r_b_valid && out_free;
    assign b_free   = !r_b_valid || out_free;
    assign a_adv    = r_a_valid && b_free;
    assign a_free   = !r_a_valid || b_free;
    assign i_req.ready = a_free && r_clr_done;
    assign a_accept = i_req.valid && i_req.ready;

    sacl_index #(
        .SETS         (SETS),
        .LINE_BYTES   (LINE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_index (
        .i_clk  (i_clk),
        .i_load (a_accept),
        .i_addr (i_req.access_address),
        .o_set  (a_set),
        .o_tag  (a_tag)
    );

    assign st_we    = clearing || b_adv;
    assign st_waddr = clearing ? r_clr_cnt : r_b_set;
    assign st_wdata = clearing ? '0 : state_new;

    sacl_ram #(
        .WIDTH (ST_W),
        .DEPTH (SETS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (a_adv),
        .i_raddr (a_set),
        .o_rdata (st_rdata)
    );

    sacl_ram #(
        .WIDTH (TR_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (b_adv),
        .i_waddr (r_b_set),
        .i_wdata (tags_new),
        .i_re    (a_adv),
        .i_raddr (a_set),
        .o_rdata (tag_rdata)
    );

    // row written by the previous access to the same set bypasses the stale read
    assign b_state     = r_fwd ? r_fwd_state : st_rdata;
    assign b_tags_flat = r_fwd ? r_fwd_tags : tag_rdata;
    assign b_valid     = b_state[WAYS-1:0];
    assign b_age       = b_state[ST_W-1:WAYS];
    assign b_tags      = b_tags_flat;

    sacl_way_sel #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_way_sel (
        .i_valid      (b_valid),
        .i_age        (b_age),
        .i_tag_row    (b_tags),
        .i_tag        (r_b_tag),
        .o_flags      (b_flags),
        .o_way        (b_way),
        .o_valid_next (valid_next),
        .o_age_next   (age_next)
    );

    always_comb begin
        tags_next = b_tags;
        tags_next[b_way] = r_b_tag;
    end

    assign state_new  = {age_next, valid_next};
    assign tags_new   = tags_next;
    assign n_hit_cnt  = r_hit_cnt + CNT_W'(b_flags.hit);
    assign n_miss_cnt = r_miss_cnt + CNT_W'(!b_flags.hit);
    assign way_ext    = (WAY_W + 2)'(b_way);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_done  <= 1'b0;
            r_clr_cnt   <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
        end else begin
            if (clearing) begin
                if (r_clr_cnt == SET_W'(SETS - 1)) begin
                    r_clr_done <= 1'b1;
                end else begin
                    r_clr_cnt <= r_clr_cnt + SET_W'(1);
                end
            end
            if (a_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_out_valid <= 1'b1;
                r_hit_cnt   <= n_hit_cnt;
                r_miss_cnt  <= n_miss_cnt;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_set     <= a_set;
            r_b_tag     <= a_tag;
            r_fwd       <= b_adv && (r_b_set == a_set);
            r_fwd_state <= state_new;
            r_fwd_tags  <= tags_new;
        end
        if (b_adv) begin
            r_out_hit        <= b_flags.hit;
            r_out_evicted    <= b_flags.evicted;
            r_out_way        <= way_ext[WAY_OUT_W-1:0];
            r_out_hit_total  <= n_hit_cnt;
            r_out_miss_total <= n_miss_cnt;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.way_used   = r_out_way;
    assign o_rsp.evicted    = r_out_evicted;
    assign o_rsp.hit_total  = r_out_hit_total;
    assign o_rsp.miss_total = r_out_miss_total;

endmodule
